// ===== sv/fbfl_pkg.sv =====
// Shared types, widths and codes for the fixed block free-list allocator.
package fbfl_pkg;

  localparam int DEF_NUM_BLOCKS = 256;

  localparam int OPCODE_W = 2;
  localparam int SIZE_W   = 16;
  localparam int BIDX_W   = 8;
  localparam int STATUS_W = 2;
  localparam int GIDX_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int POOL_W   = 9;

  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
  localparam logic [POOL_W-1:0] POOL_BLOCKS_RST = 9'd256;

  localparam int CMD_FIFO_DEPTH = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERSIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_OWNED = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE  = 1'b0,
    REG_POOL_BLOCKS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_OVERSIZE,
    CMD_FREE,
    CMD_REBUILD,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [BIDX_W-1:0] block_index;
    logic [POOL_W-1:0] pool_n;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ALLOC_RD,
    BK_REBUILD
  } back_state_e;

endpackage

// ===== sv/fbfl_if.sv =====
// Request and response channel interfaces for the allocator.
interface fbfl_req_if import fbfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SIZE_W-1:0]   request_size;
  logic [BIDX_W-1:0]   block_index;

  modport source (output valid, opcode, request_size, block_index, input ready);
  modport sink   (input valid, opcode, request_size, block_index, output ready);
endinterface

interface fbfl_rsp_if import fbfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [GIDX_W-1:0]   granted_index;
  logic [COUNT_W-1:0]  used_count;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, status, granted_index, used_count, free_count, input ready);
  modport sink   (input valid, status, granted_index, used_count, free_count, output ready);
endinterface

// ===== sv/fbfl_front.sv =====
// Front end: takes requests and turns them into back-end commands.
module fbfl_front import fbfl_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  fbfl_req_if.sink           req,
  input  logic [SIZE_W-1:0]  block_size_i,
  input  logic [POOL_W-1:0]  pool_blocks_i,
  input  logic               fifo_full_i,
  output cmd_slot_t          push_o
);

  localparam int LinkW = $clog2(NUM_BLOCKS + 1);
  localparam int WideW = (LinkW > POOL_W) ? LinkW : POOL_W;

  logic [POOL_W-1:0] pool_n;

  // rebuild never places more blocks than the link memory holds
  always_comb begin
    if (WideW'(pool_blocks_i) > WideW'(NUM_BLOCKS)) begin
      pool_n = POOL_W'(NUM_BLOCKS);
    end else begin
      pool_n = pool_blocks_i;
    end
  end

  assign req.ready = !fifo_full_i;

  always_comb begin
    push_o.valid            = req.valid && !fifo_full_i;
    push_o.cmd.block_index  = req.block_index;
    push_o.cmd.pool_n       = pool_n;
    unique case (req.opcode)
      OP_ALLOC: begin
        // size check wins over an empty list
        if (req.request_size > block_size_i) begin
          push_o.cmd.kind = CMD_OVERSIZE;
        end else begin
          push_o.cmd.kind = CMD_ALLOC;
        end
      end
      OP_FREE:    push_o.cmd.kind = CMD_FREE;
      OP_REBUILD: push_o.cmd.kind = CMD_REBUILD;
      default:    push_o.cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== sv/fbfl_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
module fbfl_cmd_fifo import fbfl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_slot_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output cmd_slot_t head_o
);

  localparam int PtrW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            entry_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(CMD_FIFO_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ===== sv/fbfl_back.sv =====
// Back end: free-list head, counters, link memory and the response register.
module fbfl_back import fbfl_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_slot_t  cmd_i,
  output logic       pop_o,
  fbfl_rsp_if.source rsp
);

  localparam int IdxW  = $clog2(NUM_BLOCKS);
  localparam int LinkW = $clog2(NUM_BLOCKS + 1);
  localparam int WideW = (LinkW > POOL_W) ? LinkW : POOL_W;
  localparam logic [LinkW-1:0] Empty = LinkW'(NUM_BLOCKS);
  localparam logic [LinkW-1:0] Full  = LinkW'(NUM_BLOCKS);

  logic [LinkW-1:0] link_mem [NUM_BLOCKS];
  logic [LinkW-1:0] rd_data_q;

  back_state_e      state_q, state_d;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] used_q, used_d;
  logic [LinkW-1:0] cap_q, cap_d;
  logic [LinkW-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  status_e          status_q;
  logic [GIDX_W-1:0]  granted_q;
  logic [COUNT_W-1:0] used_cnt_q;
  logic [COUNT_W-1:0] free_cnt_q;

  logic             slot_free;
  logic             emit;
  status_e          res_status;
  logic [LinkW-1:0] res_granted;
  logic [LinkW-1:0] res_free;
  logic [WideW-1:0] idx_wide;
  logic [WideW-1:0] n_wide;
  logic [WideW-1:0] granted_wide;
  logic [WideW-1:0] used_wide;
  logic [WideW-1:0] free_wide;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [LinkW-1:0] mem_wdata;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;

  assign slot_free = !out_vld_q || rsp.ready;
  assign idx_wide  = WideW'(cmd_i.cmd.block_index);
  assign n_wide    = WideW'(cmd_i.cmd.pool_n);

  // commands leave the queue only when their response is produced
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    used_d      = used_q;
    cap_d       = cap_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    emit        = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    mem_we      = 1'b0;
    mem_waddr   = idx_wide[IdxW-1:0];
    mem_wdata   = head_q;
    mem_re      = 1'b0;
    mem_raddr   = head_q[IdxW-1:0];
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_i.valid && slot_free) begin
          unique case (cmd_i.cmd.kind)
            CMD_OVERSIZE: begin
              pop_o      = 1'b1;
              emit       = 1'b1;
              res_status = ST_OVERSIZE;
            end
            CMD_ALLOC: begin
              if (head_q == Empty) begin
                pop_o      = 1'b1;
                emit       = 1'b1;
                res_status = ST_EXHAUSTED;
              end else begin
                mem_re  = 1'b1;
                state_d = BK_ALLOC_RD;
              end
            end
            CMD_FREE: begin
              pop_o = 1'b1;
              emit  = 1'b1;
              if (idx_wide < WideW'(cap_q)) begin
                mem_we = 1'b1;
                head_d = idx_wide[LinkW-1:0];
                used_d = (used_q == '0) ? '0 : used_q - LinkW'(1);
              end else begin
                res_status = ST_NOT_OWNED;
              end
            end
            CMD_REBUILD: begin
              head_d  = Empty;
              cnt_d   = '0;
              state_d = BK_REBUILD;
            end
            default: begin
              pop_o = 1'b1;
              emit  = 1'b1;
            end
          endcase
        end
      end
      BK_ALLOC_RD: begin
        if (slot_free) begin
          pop_o       = 1'b1;
          emit        = 1'b1;
          res_granted = head_q;
          head_d      = rd_data_q;
          used_d      = (used_q == Full) ? used_q : used_q + LinkW'(1);
          state_d     = BK_IDLE;
        end
      end
      BK_REBUILD: begin
        // one link write per block, ascending, each pushed on the head
        if (WideW'(cnt_q) < n_wide) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IdxW-1:0];
          head_d    = cnt_q;
          cnt_d     = cnt_q + LinkW'(1);
        end else if (slot_free) begin
          pop_o   = 1'b1;
          emit    = 1'b1;
          cap_d   = n_wide[LinkW-1:0];
          used_d  = '0;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign res_free     = (cap_d > used_d) ? cap_d - used_d : '0;
  assign granted_wide = WideW'(res_granted);
  assign used_wide    = WideW'(used_d);
  assign free_wide    = WideW'(res_free);

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (rsp.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      head_q    <= Empty;
      used_q    <= '0;
      cap_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      used_q    <= used_d;
      cap_q     <= cap_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q   <= res_status;
      granted_q  <= granted_wide[GIDX_W-1:0];
      used_cnt_q <= used_wide[COUNT_W-1:0];
      free_cnt_q <= free_wide[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= link_mem[mem_raddr];
    end
  end

  assign rsp.valid         = out_vld_q;
  assign rsp.status        = status_q;
  assign rsp.granted_index = granted_q;
  assign rsp.used_count    = used_cnt_q;
  assign rsp.free_count    = free_cnt_q;

endmodule

// ===== sv/fixed_block_free_list_allocator_unit.sv =====
// Fixed-size block allocator: pool of NUM_BLOCKS equal blocks on a LIFO free list, with
// next-links in a single-port link memory. Requests enter a two-entry command queue at up
// to one per cycle while not full. The back end answers an oversize, exhausted, free,
// not-owned or unused-opcode request directly, a successful allocate by a registered
// link-memory read, then head update, and a rebuild by writing one link per cycle for
// pool_blocks (clamped to NUM_BLOCKS) blocks. Each request yields one response
// through an output register. The link memory needs no clearing after reset; the list is
// empty until the first rebuild. Registers: block_size at 0x0, pool_blocks at 0x4.
module fixed_block_free_list_allocator_unit import fbfl_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fbfl_req_if.sink              req_i,
  fbfl_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SIZE_W-1:0] block_size_q;
  logic [POOL_W-1:0] pool_blocks_q;
  reg_idx_e          reg_sel;
  logic              cfg_wr;

  cmd_slot_t push;
  cmd_slot_t head;
  logic      fifo_full;
  logic      pop;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[REG_IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= BLOCK_SIZE_RST;
      pool_blocks_q <= POOL_BLOCKS_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BLOCK_SIZE:  block_size_q  <= pwdata[SIZE_W-1:0];
        REG_POOL_BLOCKS: pool_blocks_q <= pwdata[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_SIZE:  prdata = APB_DATA_W'(block_size_q);
      REG_POOL_BLOCKS: prdata = APB_DATA_W'(pool_blocks_q);
      default:         prdata = '0;
    endcase
  end

  fbfl_front #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_front (
    .req          (req_i),
    .block_size_i (block_size_q),
    .pool_blocks_i(pool_blocks_q),
    .fifo_full_i  (fifo_full),
    .push_o       (push)
  );

  fbfl_cmd_fifo u_cmd_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .full_o(fifo_full),
    .head_o(head)
  );

  fbfl_back #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (head),
    .pop_o (pop),
    .rsp   (rsp_o)
  );

endmodule

// ===== sv/fbfl_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
module fbfl_checker import fbfl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [GIDX_W-1:0]   rsp_granted_i,
  input logic [COUNT_W-1:0]  rsp_used_i,
  input logic [COUNT_W-1:0]  rsp_free_i
);

  logic [2:0] outstanding_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = req_valid_i && req_ready_i;
  assign out_xfer = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding_q <= outstanding_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      outstanding_q <= outstanding_q - 3'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({rsp_status_i, rsp_granted_i, rsp_used_i, rsp_free_i}))
    else $error("response changed while stalled");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_granted_i == '0)
    else $error("failed request carries a granted index");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> outstanding_q != 3'd0)
    else $error("response without a pending request");

  a_bounded_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'd3)
    else $error("more requests pending than queue and output can hold");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker u_fbfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_granted_i(rsp_o.granted_index),
  .rsp_used_i   (rsp_o.used_count),
  .rsp_free_i   (rsp_o.free_count)
);

// ===== verif/fixed_block_free_list_allocator_unit_tb.sv =====
// Self-checking testbench for the fixed block free-list allocator unit.
module fixed_block_free_list_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbfl_pkg::*;

  localparam int POOL_SIZE = DEF_NUM_BLOCKS;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    status_e            status;
    logic [GIDX_W-1:0]  granted;
    logic [COUNT_W-1:0] used_cnt;
    logic [COUNT_W-1:0] free_cnt;
  } alloc_rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fbfl_req_if req_if ();
  fbfl_rsp_if rsp_if ();

  fixed_block_free_list_allocator_unit #(
    .NUM_BLOCKS(POOL_SIZE)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow of the allocator state
  int unsigned       link_mem [POOL_SIZE];
  int unsigned       list_head;
  int unsigned       blocks_out;
  int unsigned       pool_cap;
  logic [SIZE_W-1:0] cfg_block_size;
  logic [POOL_W-1:0] cfg_pool_blocks;

  alloc_rsp_t        expected_rsp_q [$];
  logic [BIDX_W-1:0] handed_out_q [$];
  int unsigned       mismatches;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic alloc_rsp_t predict_alloc_step(logic [OPCODE_W-1:0] op,
                                                    logic [SIZE_W-1:0] sz,
                                                    logic [BIDX_W-1:0] bi);
    alloc_rsp_t  r;
    int unsigned n;
    r.status  = ST_OK;
    r.granted = '0;
    case (op)
      OP_ALLOC: begin
        // size check wins over an empty list
        if (sz > cfg_block_size) begin
          r.status = ST_OVERSIZE;
        end else if (list_head >= POOL_SIZE) begin
          r.status = ST_EXHAUSTED;
        end else begin
          r.granted = list_head[GIDX_W-1:0];
          list_head = link_mem[list_head];
          if (list_head > POOL_SIZE) list_head = POOL_SIZE;
          if (blocks_out < POOL_SIZE) blocks_out++;
        end
      end
      OP_FREE: begin
        if (bi >= pool_cap) begin
          r.status = ST_NOT_OWNED;
        end else begin
          link_mem[bi] = list_head;
          list_head    = bi;
          if (blocks_out > 0) blocks_out--;
        end
      end
      OP_REBUILD: begin
        n = (cfg_pool_blocks > POOL_SIZE) ? POOL_SIZE : cfg_pool_blocks;
        list_head = POOL_SIZE;
        for (int unsigned i = 0; i < n; i++) begin
          link_mem[i] = list_head;
          list_head   = i;
        end
        pool_cap   = n;
        blocks_out = 0;
      end
      default: ;
    endcase
    r.used_cnt = COUNT_W'(blocks_out);
    r.free_cnt = (pool_cap > blocks_out) ? COUNT_W'(pool_cap - blocks_out) : '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    alloc_rsp_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d granted %0d used %0d free %0d",
                                  rsp_if.status, rsp_if.granted_index, rsp_if.used_count,
                                  rsp_if.free_count));
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (rsp_if.status !== exp_r.status || rsp_if.granted_index !== exp_r.granted ||
            rsp_if.used_count !== exp_r.used_cnt || rsp_if.free_count !== exp_r.free_cnt) begin
          report_mismatch($sformatf(
            "mismatch exp/act: status %0d/%0d granted %0d/%0d used %0d/%0d free %0d/%0d",
            exp_r.status, rsp_if.status, exp_r.granted, rsp_if.granted_index,
            exp_r.used_cnt, rsp_if.used_count, exp_r.free_cnt, rsp_if.free_count));
        end
      end
    end
  end

  // Response-side backpressure in random bursts
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; leaves valid high unless a gap is taken.
  task automatic send_op(logic [OPCODE_W-1:0] op, logic [SIZE_W-1:0] sz,
                         logic [BIDX_W-1:0] bi);
    alloc_rsp_t exp_r;
    req_if.valid        = 1'b1;
    req_if.opcode       = op;
    req_if.request_size = sz;
    req_if.block_index  = bi;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    exp_r = predict_alloc_step(op, sz, bi);
    expected_rsp_q = {expected_rsp_q, exp_r};
    if (op == OP_ALLOC && exp_r.status == ST_OK) handed_out_q = {handed_out_q, exp_r.granted};
    if (op == OP_REBUILD) handed_out_q.delete();
    @(negedge clk_i);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    req_if.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_BLOCK_SIZE:  cfg_block_size  = value[SIZE_W-1:0];
      REG_POOL_BLOCKS: cfg_pool_blocks = value[POOL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Right after reset: no rebuild yet, so nothing is owned and the list is empty
  task automatic test_empty_pool();
    send_op(OP_ALLOC, 16'd64, 8'd0);
    send_op(OP_ALLOC, 16'hFFFF, 8'hFF);
    send_op(OP_FREE, 16'd0, 8'd0);
    send_op(OP_FREE, 16'hFFFF, 8'hFF);
    send_op(OP_UNUSED, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_small_pool_edges();
    wait_results_drained();
    cfg_write(REG_BLOCK_SIZE, 32'd0);
    cfg_write(REG_POOL_BLOCKS, 32'd2);
    send_op(OP_REBUILD, 16'hFFFF, 8'hFF);
    send_op(OP_ALLOC, 16'd0, 8'hFF);
    send_op(OP_ALLOC, 16'd1, 8'd0);
    send_op(OP_ALLOC, 16'd0, 8'd0);
    send_op(OP_ALLOC, 16'd0, 8'd0);     // list empty
    send_op(OP_ALLOC, 16'hFFFF, 8'd0);  // oversize reported ahead of empty
    send_op(OP_FREE, 16'hFFFF, 8'd2);   // first index past capacity
    send_op(OP_FREE, 16'd0, 8'd1);
    send_op(OP_FREE, 16'd0, 8'd1);      // double free goes through
    send_op(OP_ALLOC, 16'd0, 8'd0);
    send_op(OP_ALLOC, 16'd0, 8'd0);
  endtask

  task automatic test_pool_edges();
    wait_results_drained();
    cfg_write(REG_BLOCK_SIZE, 32'hFFFF);
    cfg_write(REG_POOL_BLOCKS, 32'd511);  // clamps to the memory size
    send_op(OP_REBUILD, 16'd0, 8'd0);
    send_op(OP_ALLOC, 16'hFFFF, 8'd0);
    send_op(OP_FREE, 16'd0, 8'd0);
    send_op(OP_FREE, 16'd0, 8'd255);      // used count already zero
    wait_results_drained();
    cfg_write(REG_POOL_BLOCKS, 32'd0);
    send_op(OP_REBUILD, 16'd0, 8'd0);
    send_op(OP_ALLOC, 16'd0, 8'd0);
    send_op(OP_FREE, 16'd0, 8'd0);
  endtask

  // A block freed twice while on top of the list links to itself, so allocs
  // keep returning it and the used count runs up to its ceiling.
  task automatic test_double_free_saturation();
    wait_results_drained();
    cfg_write(REG_BLOCK_SIZE, 32'd64);
    cfg_write(REG_POOL_BLOCKS, 32'd1);
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    send_op(OP_REBUILD, 16'($urandom), 8'($urandom));
    send_op(OP_ALLOC, 16'd0, 8'($urandom));
    send_op(OP_FREE, 16'($urandom), 8'd0);
    send_op(OP_FREE, 16'($urandom), 8'd0);
    repeat (262) send_op(OP_ALLOC, 16'($urandom_range(0, 64)), 8'($urandom));
    repeat (2) send_op(OP_FREE, 16'($urandom), 8'd0);
  endtask

  task automatic test_random_traffic(int unsigned n_items, logic [SIZE_W-1:0] bs,
                                     logic [POOL_W-1:0] pool, int unsigned tx_pct,
                                     int unsigned rx_pct);
    int unsigned pick;
    int unsigned k;
    logic [SIZE_W-1:0] sz;
    wait_results_drained();
    cfg_write(REG_BLOCK_SIZE, 32'(bs));
    cfg_write(REG_POOL_BLOCKS, 32'(pool));
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_op(OP_REBUILD, 16'($urandom), 8'($urandom));
    for (int unsigned i = 1; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        k = $urandom_range(0, 9);
        if (k < 8) sz = 16'($urandom_range(0, cfg_block_size));
        else if (k == 8 && cfg_block_size != 16'hFFFF)
          sz = 16'($urandom_range(cfg_block_size + 1, 16'hFFFF));
        else sz = 16'($urandom);
        send_op(OP_ALLOC, sz, 8'($urandom));
      end else if (pick < 80 && handed_out_q.size() != 0) begin
        k = $urandom_range(0, handed_out_q.size() - 1);
        send_op(OP_FREE, 16'($urandom), handed_out_q[k]);
        handed_out_q.delete(k);
      end else if (pick < 90) begin
        send_op(OP_FREE, 16'($urandom), 8'($urandom));
      end else if (pick < 94) begin
        send_op(OP_REBUILD, 16'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        send_op(OP_UNUSED, 16'($urandom), 8'($urandom));
      end else begin
        // hold off until the pipeline is empty, then carry on
        wait_results_drained();
        send_op(OP_ALLOC, 16'($urandom_range(0, cfg_block_size)), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.opcode       = '0;
    req_if.request_size = '0;
    req_if.block_index  = '0;
    mismatches          = 0;
    tx_idle_pct         = 0;
    rx_idle_pct         = 0;
    cfg_block_size      = BLOCK_SIZE_RST;
    cfg_pool_blocks     = POOL_BLOCKS_RST;
    list_head           = POOL_SIZE;
    blocks_out          = 0;
    pool_cap            = 0;
    foreach (link_mem[i]) link_mem[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_pool();
    test_small_pool_edges();
    test_pool_edges();
    test_double_free_saturation();
    test_random_traffic(130, 16'd64, 9'd256, 20, 20);
    test_random_traffic(130, 16'd0, 9'd256, 5, 40);
    test_random_traffic(130, 16'hFFFF, 9'd511, 40, 5);
    test_random_traffic(130, 16'($urandom), 9'd0, 20, 20);
    test_random_traffic(130, 16'($urandom_range(0, 300)), 9'($urandom_range(1, 8)), 20, 20);
    test_random_traffic(130, 16'($urandom), 9'($urandom_range(257, 511)), 40, 40);
    test_random_traffic(130, 16'($urandom), 9'($urandom_range(0, 256)), 5, 5);
    test_random_traffic(130, 16'd1000, 9'd17, 0, 0);

    wait_results_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
